/* hw/rtl/nld_pkg.sv */
// ----------------------------------------------------------------------------
// nld_pkg
// shared types and constants of the node label decision block
// ----------------------------------------------------------------------------
package nld_pkg;

    localparam int MAX_STATES = 16;
    localparam int VALUE_BITS = 16;
    localparam int LOSS_BITS  = 16;
    localparam int ROW_BITS   = $clog2(MAX_STATES);
    localparam int ADDR_BITS  = 2 * ROW_BITS;
    localparam int PROD_BITS  = VALUE_BITS + LOSS_BITS;
    localparam int SUM_BITS   = PROD_BITS + ROW_BITS;
    localparam int CNT_BITS   = ROW_BITS + 1;

    localparam logic [LOSS_BITS-1:0] LOSS_ONE  = 16'h8000;
    localparam logic [LOSS_BITS-1:0] LOSS_ZERO = 16'h0000;

    localparam logic KIND_POTENTIAL = 1'b0;
    localparam logic KIND_LOSS      = 1'b1;

    localparam logic REG_USE_LOSS   = 1'b0;
    localparam logic REG_NUM_STATES = 1'b1;

    localparam logic [CNT_BITS-1:0] MIN_STATES_CNT = CNT_BITS'(2);
    localparam logic [CNT_BITS-1:0] MAX_STATES_CNT = CNT_BITS'(MAX_STATES);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_OUT
    } state_t;

endpackage

/* hw/rtl/node_label_decision.sv */
// ----------------------------------------------------------------------------
// node_label_decision
// per-node label decision: maximum potential or minimum expected loss
// sequence: a potential element holds the input through the accept, one
//   multiply-add pass through the loss and risk memories per label (n labels
//   in use) and a drain of the pipeline; the label of a completed node is
//   loaded into the output register after that drain, once it is free
// throughput: no new potential element until the last one has drained, one
//   loss write per cycle while no potential element is in flight
// reset: default loss matrix and cleared risk sums at once, no clearing pass
// ----------------------------------------------------------------------------
module node_label_decision
    import nld_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    // apb configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // input stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // value[15:0], loss_row[19:16], loss_col[23:20]
    input  logic        s_axis_tuser,   // kind[0]
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata    // label[3:0], zero fill[7:4]
);

    state_t state_reg, state_next;

    logic                  use_loss_reg;
    logic [CNT_BITS-1:0]   num_states_reg;
    logic [CNT_BITS-1:0]   n_eff;

    logic [ROW_BITS-1:0]   elem_cnt_reg, elem_cnt_next;
    logic [VALUE_BITS-1:0] best_val_reg, best_val_next;
    logic [ROW_BITS-1:0]   best_idx_reg, best_idx_next;
    logic [ROW_BITS-1:0]   col_reg, col_next;
    logic [VALUE_BITS-1:0] pot_reg, pot_next;
    logic                  last_reg, last_next;
    logic [ROW_BITS-1:0]   row_reg, row_next;

    logic                  p1_valid_reg;
    logic [ROW_BITS-1:0]   p1_row_reg;
    logic                  p2_valid_reg;
    logic [ROW_BITS-1:0]   p2_row_reg;
    logic [PROD_BITS-1:0]  prod_reg;
    logic [SUM_BITS-1:0]   p2_sum_reg;

    logic [SUM_BITS-1:0]   min_val_reg;
    logic [ROW_BITS-1:0]   min_idx_reg;

    logic                  m_valid_reg, m_valid_next;
    logic [ROW_BITS-1:0]   m_label_reg, m_label_next;

    logic [SUM_BITS-1:0]   rs_mem [MAX_STATES];
    logic [MAX_STATES-1:0] rs_valid_reg;
    logic [SUM_BITS-1:0]   rs_q_reg;
    logic                  rs_vld_q_reg;
    logic                  rs_clear;

    logic                  cfg_wr;
    logic                  s_accept;
    logic                  s_kind;
    logic [VALUE_BITS-1:0] s_value;
    logic [ROW_BITS-1:0]   s_row;
    logic [ROW_BITS-1:0]   s_col;
    logic                  loss_wr;
    logic [LOSS_BITS-1:0]  loss_rd_data;
    logic [SUM_BITS-1:0]   new_sum;
    logic                  issue;

    assign s_kind  = s_axis_tuser;
    assign s_value = s_axis_tdata[15:0];
    assign s_row   = s_axis_tdata[19:16];
    assign s_col   = s_axis_tdata[23:20];

    // configuration
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            use_loss_reg   <= 1'b0;
            num_states_reg <= MAX_STATES_CNT;
        end else if (cfg_wr) begin
            unique case (paddr[2])
                REG_USE_LOSS:   use_loss_reg   <= pwdata[0];
                REG_NUM_STATES: num_states_reg <= pwdata[CNT_BITS-1:0];
                default:        ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_USE_LOSS:   prdata = {31'b0, use_loss_reg};
            REG_NUM_STATES: prdata = {{(32-CNT_BITS){1'b0}}, num_states_reg};
            default:        prdata = '0;
        endcase
    end

    always_comb begin
        if (num_states_reg < MIN_STATES_CNT) begin
            n_eff = MIN_STATES_CNT;
        end else if (num_states_reg > MAX_STATES_CNT) begin
            n_eff = MAX_STATES_CNT;
        end else begin
            n_eff = num_states_reg;
        end
    end

    // input handshake
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign s_accept      = s_axis_tvalid && s_axis_tready;
    assign loss_wr       = s_accept && (s_kind == KIND_LOSS);
    assign issue         = (state_reg == ST_ISSUE);

    nld_loss_mem u_loss_mem (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (loss_wr),
        .wr_addr ({s_row, s_col}),
        .wr_data (s_value),
        .rd_addr ({row_reg, col_reg}),
        .rd_data (loss_rd_data)
    );

    // control and per-node registers
    always_comb begin
        state_next    = state_reg;
        elem_cnt_next = elem_cnt_reg;
        best_val_next = best_val_reg;
        best_idx_next = best_idx_reg;
        col_next      = col_reg;
        pot_next      = pot_reg;
        last_next     = last_reg;
        row_next      = row_reg;
        m_valid_next  = m_valid_reg && !m_axis_tready;
        m_label_next  = m_label_reg;
        rs_clear      = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_accept && (s_kind == KIND_POTENTIAL)) begin
                    col_next  = elem_cnt_reg;
                    pot_next  = s_value;
                    row_next  = '0;
                    last_next = ({1'b0, elem_cnt_reg} + CNT_BITS'(1)) >= n_eff;
                    if ((elem_cnt_reg == '0) || (s_value > best_val_reg)) begin
                        best_val_next = s_value;
                        best_idx_next = elem_cnt_reg;
                    end
                    if (({1'b0, elem_cnt_reg} + CNT_BITS'(1)) < n_eff) begin
                        elem_cnt_next = elem_cnt_reg + ROW_BITS'(1);
                    end
                    state_next = ST_ISSUE;
                end
            end
            ST_ISSUE: begin
                if (({1'b0, row_reg} + CNT_BITS'(1)) >= n_eff) begin
                    state_next = ST_DRAIN;
                end else begin
                    row_next = row_reg + ROW_BITS'(1);
                end
            end
            ST_DRAIN: begin
                if (!p1_valid_reg && !p2_valid_reg) begin
                    state_next = last_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_axis_tready) begin
                    m_valid_next  = 1'b1;
                    m_label_next  = use_loss_reg ? min_idx_reg : best_idx_reg;
                    elem_cnt_next = '0;
                    best_val_next = '0;
                    best_idx_next = '0;
                    rs_clear      = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            elem_cnt_reg <= '0;
            best_val_reg <= '0;
            best_idx_reg <= '0;
            last_reg     <= 1'b0;
            row_reg      <= '0;
            m_valid_reg  <= 1'b0;
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            elem_cnt_reg <= elem_cnt_next;
            best_val_reg <= best_val_next;
            best_idx_reg <= best_idx_next;
            last_reg     <= last_next;
            row_reg      <= row_next;
            m_valid_reg  <= m_valid_next;
            p1_valid_reg <= issue;
            p2_valid_reg <= p1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        col_reg     <= col_next;
        pot_reg     <= pot_next;
        m_label_reg <= m_label_next;
    end

    // risk sum memory: read, multiply-add, write back
    always_ff @(posedge aclk) begin
        if (p2_valid_reg) begin
            rs_mem[p2_row_reg] <= new_sum;
        end
        rs_q_reg <= rs_mem[row_reg];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rs_valid_reg <= '0;
            rs_vld_q_reg <= 1'b0;
        end else begin
            if (rs_clear) begin
                rs_valid_reg <= '0;
            end else if (p2_valid_reg) begin
                rs_valid_reg[p2_row_reg] <= 1'b1;
            end
            rs_vld_q_reg <= rs_valid_reg[row_reg];
        end
    end

    assign new_sum = p2_sum_reg + SUM_BITS'(prod_reg);

    always_ff @(posedge aclk) begin
        p1_row_reg <= row_reg;
        p2_row_reg <= p1_row_reg;
        prod_reg   <= PROD_BITS'(loss_rd_data) * PROD_BITS'(pot_reg);
        p2_sum_reg <= rs_vld_q_reg ? rs_q_reg : '0;
        // rows arrive in order, so a tie keeps the first row
        if (p2_valid_reg && ((p2_row_reg == '0) || (new_sum < min_val_reg))) begin
            min_val_reg <= new_sum;
            min_idx_reg <= p2_row_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {4'b0, m_label_reg};

endmodule

/* hw/rtl/nld_loss_mem.sv */
// ----------------------------------------------------------------------------
// nld_loss_mem
// loss table memory, registered read, entries never written read as
// the default matrix (one off the diagonal, zero on it)
// ----------------------------------------------------------------------------
module nld_loss_mem
    import nld_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [LOSS_BITS-1:0] wr_data,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [LOSS_BITS-1:0] rd_data
);

    localparam int DEPTH = MAX_STATES * MAX_STATES;

    logic [LOSS_BITS-1:0] mem [DEPTH];
    logic [DEPTH-1:0]     valid_reg;
    logic [LOSS_BITS-1:0] rd_q_reg;
    logic                 rd_valid_reg;
    logic                 rd_diag_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_q_reg <= mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
            rd_diag_reg  <= 1'b0;
        end else begin
            if (wr_en) begin
                valid_reg[wr_addr] <= 1'b1;
            end
            rd_valid_reg <= valid_reg[rd_addr];
            rd_diag_reg  <= (rd_addr[ADDR_BITS-1:ROW_BITS] == rd_addr[ROW_BITS-1:0]);
        end
    end

    assign rd_data = rd_valid_reg ? rd_q_reg : (rd_diag_reg ? LOSS_ZERO : LOSS_ONE);

endmodule
